@@ hw/rtl/lebu_pkg.sv @@
// shared types and constants of the line edit buffer
`timescale 1ns / 1ps

package lebu_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned EVENT_W = 3;

  localparam logic [KEY_W-1:0] KEY_TAB    = 8'h09;
  localparam logic [KEY_W-1:0] KEY_LF     = 8'h0A;
  localparam logic [KEY_W-1:0] KEY_CR     = 8'h0D;
  localparam logic [KEY_W-1:0] KEY_CTRL_C = 8'h03;
  localparam logic [KEY_W-1:0] KEY_CTRL_D = 8'h04;
  localparam logic [KEY_W-1:0] KEY_ESC    = 8'h1B;
  localparam logic [KEY_W-1:0] KEY_CSI    = 8'h5B;
  localparam logic [KEY_W-1:0] KEY_BS     = 8'h7F;
  localparam logic [KEY_W-1:0] KEY_UP     = 8'h41;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 8'h42;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h43;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h44;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_EOI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_EDIT   = 3'd0,
    EV_DONE   = 3'd1,
    EV_ABORT  = 3'd2,
    EV_ESCERR = 3'd3,
    EV_FULL   = 3'd4,
    EV_READ   = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } esc_e;

  // controller to datapath
  typedef struct packed {
    logic   capture;
    logic   clr_done;
    logic   clr_line;
    logic   esc_load;
    esc_e   esc_val;
    logic   set_done;
    logic   cur_inc;
    logic   cur_dec;
    logic   cur_clr;
    logic   cnt_dec;
    logic   ev_load;
    event_e ev_val;
    logic   rd_item;
    logic   ins_start;
    logic   del_start;
    logic   shift_step;
    logic   shift_up;
    logic   fill;
    logic   res_load;
  } lebu_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    esc_e    esc;
    logic    done;
    logic    key_lf;
    logic    key_cr_tab;
    logic    key_bs;
    logic    key_abort;
    logic    key_esc;
    logic    key_csi;
    logic    key_ab;
    logic    key_c;
    logic    key_d;
    logic    cur_zero;
    logic    cur_end;
    logic    full;
    logic    shift_last;
    logic    out_free;
  } lebu_stat_t;

endpackage

@@ hw/rtl/line_edit_buffer_unit.sv @@
// line edit buffer top level: terminal key bytes edit a line store with a cursor
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  opcode_i, key_byte_i, read_index_i
//   out      output     out_valid_o/out_stall_i event_code_o, line_length_o,
//                                              cursor_position_o, read_char_o
//
// one request at a time; a completed line is emptied first when the next key or
// end-of-input request comes in
// insert and backspace shift the characters behind the cursor: the
// single read and write port of the line store moves one character per cycle
// reset clears length, cursor, escape state and the line-complete flag at once
// a stalled result holds in the output register while the next request is taken
`timescale 1ns / 1ps

module line_edit_buffer_unit import lebu_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [KEY_W-1:0]   key_byte_i,
  input  logic [IDX_W-1:0]   read_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [EVENT_W-1:0] event_code_o,
  output logic [IDX_W-1:0]   line_length_o,
  output logic [IDX_W-1:0]   cursor_position_o,
  output logic [KEY_W-1:0]   read_char_o
);

  lebu_cmd_t  cmd;
  lebu_stat_t stat;

  lebu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lebu_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .opcode_i          (opcode_i),
    .key_byte_i        (key_byte_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_code_o      (event_code_o),
    .line_length_o     (line_length_o),
    .cursor_position_o (cursor_position_o),
    .read_char_o       (read_char_o)
  );

endmodule

@@ hw/rtl/lebu_datapath.sv @@
// line store, cursor and length registers, shifter and result register
`timescale 1ns / 1ps

module lebu_datapath import lebu_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lebu_cmd_t            cmd_i,
  output lebu_stat_t           stat_o,
  input  logic [1:0]           opcode_i,
  input  logic [KEY_W-1:0]     key_byte_i,
  input  logic [IDX_W-1:0]     read_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [EVENT_W-1:0]   event_code_o,
  output logic [IDX_W-1:0]     line_length_o,
  output logic [IDX_W-1:0]     cursor_position_o,
  output logic [KEY_W-1:0]     read_char_o
);

  localparam int unsigned CW   = $clog2(LINE_DEPTH);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  // request capture
  opcode_e          op_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] idx_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] ptr_q, ptr_d;
  esc_e          esc_q, esc_d;
  logic          done_q, done_d;
  event_e        ev_q;
  logic          shift_up_q;

  logic [KEY_W-1:0] store_q [LINE_DEPTH];
  logic [KEY_W-1:0] rdata_q;
  logic             rd_en;
  logic [CW-1:0]    rd_addr;
  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  logic               out_valid_q;
  logic [EVENT_W-1:0] out_ev_q;
  logic [IDX_W-1:0]   out_len_q;
  logic [IDX_W-1:0]   out_cur_q;
  logic [KEY_W-1:0]   out_char_q;
  logic               idx_in_line;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_e'(opcode_i);
      key_q <= key_byte_i;
      idx_q <= read_index_i;
    end
    if (cmd_i.ev_load) begin
      ev_q <= cmd_i.ev_val;
    end
    // direction of the move in flight
    if (cmd_i.ins_start || cmd_i.del_start) begin
      shift_up_q <= cmd_i.ins_start;
    end
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    esc_d    = esc_q;
    done_d   = done_q;
    if (cmd_i.clr_line) begin
      count_d  = '0;
      cursor_d = '0;
      esc_d    = ESC_IDLE;
    end else begin
      if (cmd_i.fill) begin
        count_d  = count_q + CW'(1);
        cursor_d = cursor_q + CW'(1);
      end
      if (cmd_i.cnt_dec) begin
        count_d = count_q - CW'(1);
      end
      if (cmd_i.cur_inc) begin
        cursor_d = cursor_q + CW'(1);
      end
      if (cmd_i.cur_dec) begin
        cursor_d = cursor_q - CW'(1);
      end
      if (cmd_i.cur_clr) begin
        cursor_d = '0;
      end
      if (cmd_i.esc_load) begin
        esc_d = cmd_i.esc_val;
      end
    end
    if (cmd_i.clr_done) begin
      done_d = 1'b0;
    end else if (cmd_i.set_done) begin
      done_d = 1'b1;
    end
  end

  // shift pointer: write index of the move in flight
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ins_start) begin
      ptr_d = count_q;
    end else if (cmd_i.del_start) begin
      ptr_d = cursor_q - CW'(1);
    end else if (cmd_i.shift_step) begin
      ptr_d = cmd_i.shift_up ? ptr_q - CW'(1) : ptr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      esc_q    <= ESC_IDLE;
      done_q   <= 1'b0;
      ptr_q    <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      esc_q    <= esc_d;
      done_q   <= done_d;
      ptr_q    <= ptr_d;
    end
  end

  // read runs one position ahead of the write so one move lands per cycle
  assign rd_en = cmd_i.rd_item | cmd_i.ins_start | cmd_i.del_start | cmd_i.shift_step;

  always_comb begin
    priority if (cmd_i.rd_item) begin
      rd_addr = CW'(idx_q);
    end else if (cmd_i.ins_start) begin
      rd_addr = count_q - CW'(1);
    end else if (cmd_i.del_start) begin
      rd_addr = cursor_q;
    end else if (cmd_i.shift_up) begin
      rd_addr = ptr_q - CW'(2);
    end else begin
      rd_addr = ptr_q + CW'(2);
    end
  end

  assign wr_en   = cmd_i.shift_step | cmd_i.fill;
  assign wr_addr = cmd_i.fill ? cursor_q : ptr_q;
  assign wr_data = cmd_i.fill ? key_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  assign idx_in_line = CMPW'(idx_q) < CMPW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_ev_q   <= ev_q;
      out_len_q  <= IDX_W'(count_q);
      out_cur_q  <= IDX_W'(cursor_q);
      out_char_q <= ((ev_q == EV_READ) && idx_in_line) ? rdata_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_code_o      = out_ev_q;
  assign line_length_o     = out_len_q;
  assign cursor_position_o = out_cur_q;
  assign read_char_o       = out_char_q;

  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.esc        = esc_q;
    stat_o.done       = done_q;
    stat_o.key_lf     = key_q == KEY_LF;
    stat_o.key_cr_tab = (key_q == KEY_CR) || (key_q == KEY_TAB);
    stat_o.key_bs     = key_q == KEY_BS;
    stat_o.key_abort  = (key_q == KEY_CTRL_C) || (key_q == KEY_CTRL_D);
    stat_o.key_esc    = key_q == KEY_ESC;
    stat_o.key_csi    = key_q == KEY_CSI;
    stat_o.key_ab     = (key_q == KEY_UP) || (key_q == KEY_DOWN);
    stat_o.key_c      = key_q == KEY_RIGHT;
    stat_o.key_d      = key_q == KEY_LEFT;
    stat_o.cur_zero   = cursor_q == '0;
    stat_o.cur_end    = cursor_q == count_q;
    stat_o.full       = count_q == CW'(LINE_DEPTH - 1);
    stat_o.shift_last = shift_up_q ? (ptr_q == cursor_q + CW'(1))
                                   : (ptr_q + CW'(1) == count_q);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

@@ hw/rtl/lebu_ctrl.sv @@
// sequencing state machine of the line edit buffer
`timescale 1ns / 1ps

module lebu_ctrl import lebu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lebu_stat_t stat_i,
  output lebu_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_INS    = 6'b000100,
    S_DEL    = 6'b001000,
    S_FILL   = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end

      S_EXEC: begin
        cmd_o.ev_load = 1'b1;
        cmd_o.ev_val  = EV_EDIT;
        state_d       = S_RESULT;
        if (stat_i.done && (stat_i.op == OP_KEY || stat_i.op == OP_EOI)) begin
          // a completed line is emptied before the next edit
          cmd_o.ev_load  = 1'b0;
          cmd_o.clr_done = 1'b1;
          cmd_o.clr_line = 1'b1;
          state_d        = S_EXEC;
        end else begin
          unique case (stat_i.op)
            OP_READ: begin
              cmd_o.rd_item = 1'b1;
              cmd_o.ev_val  = EV_READ;
            end
            OP_EOI: begin
              cmd_o.clr_line = 1'b1;
              cmd_o.ev_val   = EV_ABORT;
            end
            OP_KEY: begin
              unique case (stat_i.esc)
                ESC_SEEN: begin
                  if (stat_i.key_csi) begin
                    cmd_o.esc_load = 1'b1;
                    cmd_o.esc_val  = ESC_CSI;
                  end else begin
                    cmd_o.clr_line = 1'b1;
                    cmd_o.ev_val   = EV_ESCERR;
                  end
                end
                ESC_CSI: begin
                  cmd_o.esc_load = 1'b1;
                  cmd_o.esc_val  = ESC_IDLE;
                  priority if (stat_i.key_ab) begin
                    cmd_o.ev_val = EV_EDIT;
                  end else if (stat_i.key_c) begin
                    cmd_o.cur_inc = !stat_i.cur_end;
                  end else if (stat_i.key_d) begin
                    cmd_o.cur_dec = !stat_i.cur_zero;
                  end else begin
                    cmd_o.clr_line = 1'b1;
                    cmd_o.ev_val   = EV_ESCERR;
                  end
                end
                ESC_IDLE: begin
                  priority if (stat_i.key_lf) begin
                    cmd_o.cur_clr  = 1'b1;
                    cmd_o.set_done = 1'b1;
                    cmd_o.ev_val   = EV_DONE;
                  end else if (stat_i.key_cr_tab) begin
                    cmd_o.ev_val = EV_EDIT;
                  end else if (stat_i.key_bs) begin
                    if (!stat_i.cur_zero) begin
                      cmd_o.cur_dec = 1'b1;
                      cmd_o.cnt_dec = 1'b1;
                      if (!stat_i.cur_end) begin
                        cmd_o.del_start = 1'b1;
                        state_d         = S_DEL;
                      end
                    end
                  end else if (stat_i.key_abort) begin
                    cmd_o.clr_line = 1'b1;
                    cmd_o.ev_val   = EV_ABORT;
                  end else if (stat_i.key_esc) begin
                    cmd_o.esc_load = 1'b1;
                    cmd_o.esc_val  = ESC_SEEN;
                  end else if (stat_i.full) begin
                    cmd_o.ev_val = EV_FULL;
                  end else if (stat_i.cur_end) begin
                    state_d = S_FILL;
                  end else begin
                    cmd_o.ins_start = 1'b1;
                    state_d         = S_INS;
                  end
                end
                default: begin
                  cmd_o.ev_val = EV_EDIT;
                end
              endcase
            end
            default: begin
              cmd_o.ev_val = EV_EDIT;
            end
          endcase
        end
      end

      S_INS: begin
        cmd_o.shift_step = 1'b1;
        cmd_o.shift_up   = 1'b1;
        if (stat_i.shift_last) begin
          state_d = S_FILL;
        end
      end

      S_DEL: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_last) begin
          state_d = S_RESULT;
        end
      end

      S_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = S_RESULT;
      end

      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/lebu_checker.sv @@
// port-level checks of the line edit buffer, bound to the top level
`timescale 1ns / 1ps

module lebu_checker import lebu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [EVENT_W-1:0] event_code_o,
  input logic [IDX_W-1:0]   line_length_o,
  input logic [IDX_W-1:0]   cursor_position_o,
  input logic [KEY_W-1:0]   read_char_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_code_o)
      && $stable(line_length_o) && $stable(cursor_position_o) && $stable(read_char_o))
    else $error("stalled result changed");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in progress");

  // abort and escape error empty the line
  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_code_o == EV_ABORT || event_code_o == EV_ESCERR)
      |-> line_length_o == '0 && cursor_position_o == '0)
    else $error("line not emptied on abort");

  // line complete homes the cursor
  a_done_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o == EV_DONE |-> cursor_position_o == '0)
    else $error("cursor not at start after line complete");

  // only reads carry character data
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o != EV_READ |-> read_char_o == '0)
    else $error("character data on a non-read result");

endmodule

bind line_edit_buffer_unit lebu_checker u_lebu_checker (.*);
